// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/lrsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Log record stream decoder package
// Types, codes and the CRC-32 byte update shared by the decoder.
// ----------------------------------------------------------------------------
package lrsd_pkg;

  localparam int unsigned HeaderBytes = 28;
  localparam logic [31:0] CrcOnes     = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam int unsigned MetaBytes   = 16;
  localparam int unsigned MetaCrcSpan = 12;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_TLV_HDR  = 2'd1,
    PH_TLV_BODY = 2'd2,
    PH_PAYLOAD  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HEADER      = 3'd1,
    ST_EXTENSION   = 3'd2,
    ST_META_CRC    = 3'd3,
    ST_VERSION     = 3'd4,
    ST_EMPTY       = 3'd5,
    ST_PAYLOAD_CRC = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    REG_MAGIC    = 3'd0,
    REG_KEY_TYPE = 3'd1,
    REG_META_TYPE = 3'd2,
    REG_LEGACY   = 3'd3,
    REG_CURRENT  = 3'd4,
    REG_EXT_LIM  = 3'd5,
    REG_KEY_LIM  = 3'd6
  } reg_idx_t;

  // Reflected CRC-32 update over one byte (eight shift steps).
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/log_record_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Log record stream decoder core
// Byte-serial decoder for length-prefixed log records with TLV extensions.
// ----------------------------------------------------------------------------
// Usage: record bytes enter on s_axis (tdata = data_byte, tlast = last_byte),
// one byte per transfer. Results leave on m_axis: tuser = item_kind, tlast =
// end_of_record, tdata carries out_byte, status, record_id, record_flags,
// version, enqueue_time and payload_length. Hash key and payload bytes are
// forwarded as they pass; the last byte of a run adds a summary item.
// Each byte is decoded in the cycle of its transfer and its results enter a
// three-entry registered output queue, whose head drives m_axis.
// Throughput is one byte per cycle while the receiver keeps up: s_axis_tready
// is high while at most one result waits, which leaves room for the up to two
// results of the next byte. The rate is set by the single CRC update per byte.
// Configuration is written on cfg (cfg_index, cfg_data); the user must write it
// only while the block is idle, which the block itself does not enforce. Reset
// clears the record state, the queue and the registers to their defaults. A stalled
// receiver fills the queue and then holds s_axis_tready low; nothing is dropped.
// ----------------------------------------------------------------------------
module log_record_stream_decoder_core
  import lrsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_byte[7:0], status[10:8], record_id[74:11], record_flags[106:75],
  // version[138:107], enqueue_time[202:139], payload_length[234:203], pad
  output logic [239:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // item_kind
  output logic         m_axis_tlast,   // end_of_record
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

`include "assert_macros.svh"

  typedef struct packed {
    logic [1:0]   kind;
    logic [234:0] data;
    logic         last;
  } res_t;

  // Configuration registers.
  logic [31:0] record_magic, legacy_version, current_version;
  logic [7:0]  key_ext_type, meta_ext_type;
  logic [15:0] ext_limit, key_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_magic <= '0; key_ext_type <= 8'd1; meta_ext_type <= 8'd2;
      legacy_version <= 32'd1; current_version <= 32'd2;
      ext_limit <= 16'd1024; key_limit <= 16'd256;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_MAGIC:     record_magic <= cfg_data;
        REG_KEY_TYPE:  key_ext_type <= cfg_data[7:0];
        REG_META_TYPE: meta_ext_type <= cfg_data[7:0];
        REG_LEGACY:    legacy_version <= cfg_data;
        REG_CURRENT:   current_version <= cfg_data;
        REG_EXT_LIM:   ext_limit <= cfg_data[15:0];
        REG_KEY_LIM:   key_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Record state.
  phase_t      phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] declared_length, declared_length_next;
  logic [31:0] declared_crc, declared_crc_next;
  logic [31:0] ext_remaining, ext_remaining_next;
  logic [63:0] id_word, id_word_next;
  logic [31:0] flag_word, flag_word_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] meta_crc, meta_crc_next;
  logic [7:0]  tlv_type, tlv_type_next;
  logic [15:0] tlv_remaining, tlv_remaining_next;
  logic [7:0]  meta_shift [MetaBytes];
  logic        seen_key, seen_key_next, seen_meta, seen_meta_next;
  logic        magic_ok, magic_ok_next;
  status_t     first_error, first_error_next;
  logic [1:0]  hdr_pos, hdr_pos_next;
  logic [31:0] payload_count, payload_count_next;

  logic        meta_we;
  logic [3:0]  meta_wa;

  // Output queue.
  res_t       q [3];
  res_t       q_next [3];
  logic [1:0] q_cnt, q_cnt_next;
  logic       take, pop;
  logic       emit_v, sum_v;
  res_t       emit_r, sum_r;

  assign s_axis_tready = (q_cnt <= 2'd1);
  assign take = s_axis_tvalid && s_axis_tready;
  assign pop  = m_axis_tvalid && m_axis_tready;

  // Byte decoder.
  always_comb begin
    logic [7:0]  b;
    logic [31:0] pos, mver, mcrc, ver_out;
    logic [63:0] etime;
    logic [3:0]  mp;
    logic [32:0] need;
    logic [31:0] crc_fin;
    logic [2:0]  st;
    logic        after;
    b = s_axis_tdata;
    pos = byte_count;
    phase_next = phase; byte_count_next = byte_count;
    declared_length_next = declared_length; declared_crc_next = declared_crc;
    ext_remaining_next = ext_remaining; id_word_next = id_word;
    flag_word_next = flag_word; running_crc_next = running_crc;
    meta_crc_next = meta_crc; tlv_type_next = tlv_type;
    tlv_remaining_next = tlv_remaining; seen_key_next = seen_key;
    seen_meta_next = seen_meta; magic_ok_next = magic_ok;
    first_error_next = first_error; hdr_pos_next = hdr_pos;
    payload_count_next = payload_count;
    meta_we = 1'b0; meta_wa = 4'd0; mp = 4'd0;
    emit_v = 1'b0; emit_r = '0; sum_v = 1'b0; sum_r = '0;
    after = 1'b0; st = ST_OK;
    mver = {meta_shift[3], meta_shift[2], meta_shift[1], meta_shift[0]};
    mcrc = {meta_shift[15], meta_shift[14], meta_shift[13], meta_shift[12]};
    need = 33'(HeaderBytes) + {1'b0, ext_remaining_next};
    crc_fin = '0; ver_out = '0; etime = '0;

    if (byte_count != CrcOnes) byte_count_next = byte_count + 32'd1;
    if (phase != PH_HEADER && first_error == ST_OK && pos >= declared_length)
      first_error_next = ST_HEADER;

    if (first_error_next == ST_OK) begin
      case (phase)
        PH_HEADER: begin
          if (pos < 32'd4) begin
            if (b != record_magic[8*pos[1:0] +: 8]) magic_ok_next = 1'b0;
          end else if (pos < 32'd8) begin
            declared_length_next[8*pos[1:0] +: 8] = b;
          end else if (pos < 32'd16) begin
            id_word_next[8*pos[2:0] +: 8] = b;
          end else if (pos < 32'd20) begin
            flag_word_next[8*pos[1:0] +: 8] = b;
          end else if (pos < 32'd24) begin
            declared_crc_next[8*pos[1:0] +: 8] = b;
          end else begin
            ext_remaining_next[8*pos[1:0] +: 8] = b;
          end
          need = 33'(HeaderBytes) + {1'b0, ext_remaining_next};
          if (pos == 32'(HeaderBytes - 1)) begin
            if (!magic_ok_next || ext_remaining_next > {16'd0, ext_limit} ||
                {1'b0, declared_length_next} < need)
              first_error_next = ST_HEADER;
            after = 1'b1;
          end
        end
        PH_TLV_HDR: begin
          case (hdr_pos)
            2'd0: begin
              if (ext_remaining < 32'd4) first_error_next = ST_EXTENSION;
              tlv_type_next = b;
              tlv_remaining_next = '0;
            end
            2'd2: tlv_remaining_next = {8'd0, b};
            2'd3: tlv_remaining_next = {b, tlv_remaining[7:0]};
            default: ;
          endcase
          ext_remaining_next = ext_remaining - 32'd1;
          hdr_pos_next = hdr_pos + 2'd1;
          if (first_error_next == ST_OK && hdr_pos == 2'd3) begin
            if ({16'd0, tlv_remaining_next} > ext_remaining_next) begin
              first_error_next = ST_EXTENSION;
            end else if (tlv_type_next == key_ext_type) begin
              if (seen_key || tlv_remaining_next == 16'd0 || tlv_remaining_next > key_limit)
                first_error_next = ST_EXTENSION;
              seen_key_next = 1'b1;
            end else if (tlv_type_next == meta_ext_type) begin
              if (seen_meta || tlv_remaining_next != 16'(MetaBytes))
                first_error_next = ST_EXTENSION;
              seen_meta_next = 1'b1;
              meta_crc_next = CrcOnes;
            end
            if (first_error_next == ST_OK) begin
              if (tlv_remaining_next == 16'd0) after = 1'b1;
              else phase_next = PH_TLV_BODY;
            end
          end
        end
        PH_TLV_BODY: begin
          ext_remaining_next = ext_remaining - 32'd1;
          mp = 4'(16'(MetaBytes) - tlv_remaining);
          if (tlv_type == key_ext_type) begin
            emit_v = 1'b1;
            emit_r.kind = KIND_KEY;
          end else if (tlv_type == meta_ext_type) begin
            meta_we = take; meta_wa = mp;
            if (mp < 4'(MetaCrcSpan)) meta_crc_next = crc_byte(meta_crc, b);
          end
          tlv_remaining_next = tlv_remaining - 16'd1;
          if (tlv_remaining_next == 16'd0) begin
            if (tlv_type != key_ext_type && tlv_type == meta_ext_type) begin
              // The final metadata byte is the top CRC byte (position 15).
              mcrc = {b, meta_shift[14], meta_shift[13], meta_shift[12]};
              if ((meta_crc_next ^ CrcOnes) != mcrc) first_error_next = ST_META_CRC;
              else if (mver != legacy_version && mver != current_version)
                first_error_next = ST_VERSION;
            end
            after = 1'b1;
          end
        end
        default: begin
          running_crc_next = crc_byte(running_crc, b);
          payload_count_next = payload_count + 32'd1;
          emit_v = 1'b1;
          emit_r.kind = KIND_PAYLOAD;
        end
      endcase
    end
    if (after) begin
      phase_next = (ext_remaining_next == 32'd0) ? PH_PAYLOAD : PH_TLV_HDR;
      hdr_pos_next = 2'd0;
    end
    if (first_error_next != ST_OK) emit_v = 1'b0;
    emit_r.data[7:0] = b;

    // Summary on the final byte.
    if (s_axis_tlast) begin
      crc_fin = running_crc_next ^ CrcOnes;
      if (byte_count_next < 32'(HeaderBytes) || byte_count_next != declared_length_next)
        st = ST_HEADER;
      else if (first_error_next != ST_OK) st = first_error_next;
      else if (phase_next != PH_PAYLOAD) st = ST_HEADER;
      else if (payload_count_next == 32'd0) st = ST_EMPTY;
      else if (crc_fin != declared_crc_next) st = ST_PAYLOAD_CRC;
      else st = ST_OK;
      ver_out = seen_meta_next ? mver : legacy_version;
      etime = seen_meta_next ? {meta_shift[11], meta_shift[10], meta_shift[9],
                                meta_shift[8], meta_shift[7], meta_shift[6],
                                meta_shift[5], meta_shift[4]} : 64'd0;
      sum_v = 1'b1;
      sum_r.kind = KIND_SUMMARY;
      sum_r.last = 1'b1;
      sum_r.data[10:8] = st;
      if (st == ST_OK) begin
        sum_r.data[74:11]   = id_word_next;
        sum_r.data[106:75]  = flag_word_next;
        sum_r.data[138:107] = ver_out;
        sum_r.data[202:139] = etime;
        sum_r.data[234:203] = payload_count_next;
      end
    end
  end

  // Record state registers.
  always_ff @(posedge clk) begin
    if (rst || (take && s_axis_tlast)) begin
      phase <= PH_HEADER; byte_count <= '0; declared_length <= '0;
      declared_crc <= '0; ext_remaining <= '0; id_word <= '0; flag_word <= '0;
      running_crc <= CrcOnes; meta_crc <= CrcOnes; tlv_type <= '0;
      tlv_remaining <= '0; seen_key <= 1'b0; seen_meta <= 1'b0;
      magic_ok <= 1'b1; first_error <= ST_OK; hdr_pos <= '0; payload_count <= '0;
    end else if (take) begin
      phase <= phase_next; byte_count <= byte_count_next;
      declared_length <= declared_length_next; declared_crc <= declared_crc_next;
      ext_remaining <= ext_remaining_next; id_word <= id_word_next;
      flag_word <= flag_word_next; running_crc <= running_crc_next;
      meta_crc <= meta_crc_next; tlv_type <= tlv_type_next;
      tlv_remaining <= tlv_remaining_next; seen_key <= seen_key_next;
      seen_meta <= seen_meta_next; magic_ok <= magic_ok_next;
      first_error <= first_error_next; hdr_pos <= hdr_pos_next;
      payload_count <= payload_count_next;
    end
  end

  // Metadata byte store.
  always_ff @(posedge clk) begin
    if (meta_we) meta_shift[meta_wa] <= s_axis_tdata;
  end

  // Output queue: the head leaves on a transfer, new results append behind
  // whatever remains.
  always_comb begin
    logic [1:0] n;
    q_next = q;
    n = q_cnt;
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
      n = q_cnt - 2'd1;
    end
    if (take && emit_v) begin
      q_next[n] = emit_r;
      n = n + 2'd1;
    end
    if (take && sum_v) begin
      q_next[n] = sum_r;
      n = n + 2'd1;
    end
    q_cnt_next = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else begin
      q_cnt <= q_cnt_next;
      q <= q_next;
    end
  end

  assign m_axis_tvalid = (q_cnt != 2'd0);
  assign m_axis_tuser  = q[0].kind;
  assign m_axis_tlast  = q[0].last;
  assign m_axis_tdata  = {5'd0, q[0].data};

  `ASSERT_IMPL(a_q_full_stall, clk, rst, q_cnt == 2'd3, !s_axis_tready)
  `ASSERT_IMPL(a_last_is_sum, clk, rst, m_axis_tvalid && m_axis_tlast,
               m_axis_tuser == KIND_SUMMARY)
  `ASSERT_NEXT(a_sum_follows, clk, rst, take && s_axis_tlast, m_axis_tvalid)

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Log record stream decoder testbench
// Builds whole log records, good and damaged, feeds them byte by byte with
// random gaps on both stream sides, and checks every key byte, payload byte
// and end summary against a behavioral decoder kept in a scoreboard.
// ----------------------------------------------------------------------------

// Holds the decoder's expected behavior and the results still owed.
class record_scoreboard;
  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [63:0] rec_id;
    logic [31:0] flags;
    logic [31:0] ver;
    logic [63:0] enq_time;
    logic [31:0] pay_len;
    logic        eor;
  } item_t;

  // Register copies.
  logic [31:0] magic, legacy_ver, current_ver;
  logic [7:0]  key_type, meta_type;
  logic [15:0] ext_lim, key_lim;

  // Record state.
  lrsd_pkg::phase_t ph;
  logic [31:0] count, decl_len, decl_crc, ext_left, flag_word, pay_crc, meta_crc, pay_count;
  logic [63:0] id_word;
  logic [7:0]  entry_type;
  logic [15:0] entry_left;
  logic [7:0]  meta_buf [16];
  logic        have_key, have_meta, magic_good;
  logic [2:0]  err;
  int          entry_pos;

  item_t owed[$];
  int    fails;

  function new();
    magic = 0; key_type = 1; meta_type = 2; legacy_ver = 1; current_ver = 2;
    ext_lim = 1024; key_lim = 256; fails = 0;
    clear();
  endfunction

  static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    return c;
  endfunction

  function void clear();
    ph = lrsd_pkg::PH_HEADER; count = 0; decl_len = 0; decl_crc = 0; ext_left = 0;
    id_word = 0; flag_word = 0; pay_crc = '1; meta_crc = '1; entry_type = 0;
    entry_left = 0; have_key = 0; have_meta = 0; magic_good = 1; err = 0;
    entry_pos = 0; pay_count = 0;
    for (int i = 0; i < 16; i++) meta_buf[i] = 0;
  endfunction

  function logic [63:0] meta_word(int at, int n);
    logic [63:0] v;
    v = 0;
    for (int i = 0; i < n; i++) v |= 64'(meta_buf[(at + i) & 15]) << (8 * i);
    return v;
  endfunction

  function void set_reg(lrsd_pkg::reg_idx_t idx, logic [31:0] v);
    case (idx)
      lrsd_pkg::REG_MAGIC:     magic = v;
      lrsd_pkg::REG_KEY_TYPE:  key_type = v[7:0];
      lrsd_pkg::REG_META_TYPE: meta_type = v[7:0];
      lrsd_pkg::REG_LEGACY:    legacy_ver = v;
      lrsd_pkg::REG_CURRENT:   current_ver = v;
      lrsd_pkg::REG_EXT_LIM:   ext_lim = v[15:0];
      lrsd_pkg::REG_KEY_LIM:   key_lim = v[15:0];
      default: ;
    endcase
  endfunction

  function void entry_done();
    ph = (ext_left == 0) ? lrsd_pkg::PH_PAYLOAD : lrsd_pkg::PH_TLV_HDR;
    entry_pos = 0;
  endfunction

  // Decodes one accepted byte and queues the results it causes.
  function void note_input(logic [7:0] b, logic last);
    logic [31:0] pos, v;
    int emit, mp;
    item_t it;
    logic [2:0] st;
    pos = count;
    emit = -1;
    if (count != '1) count++;
    if (ph != lrsd_pkg::PH_HEADER && err == 0 && ({1'b0, pos} + 33'd1) > {1'b0, decl_len})
      err = lrsd_pkg::ST_HEADER;
    if (err == 0) begin
      case (ph)
        lrsd_pkg::PH_HEADER: begin
          if (pos < 4) begin
            if (b != magic[8*pos +: 8]) magic_good = 0;
          end else if (pos < 8) decl_len |= 32'(b) << (8 * (pos - 4));
          else if (pos < 16) id_word |= 64'(b) << (8 * (pos - 8));
          else if (pos < 20) flag_word |= 32'(b) << (8 * (pos - 16));
          else if (pos < 24) decl_crc |= 32'(b) << (8 * (pos - 20));
          else ext_left |= 32'(b) << (8 * (pos - 24));
          if (pos == 27) begin
            if (!magic_good || ext_left > 32'(ext_lim) ||
                {32'd0, decl_len} < 64'd28 + {32'd0, ext_left})
              err = lrsd_pkg::ST_HEADER;
            entry_done();
          end
        end
        lrsd_pkg::PH_TLV_HDR: begin
          if (entry_pos == 0) begin
            if (ext_left < 4) err = lrsd_pkg::ST_EXTENSION;
            entry_type = b;
            entry_left = 0;
          end else if (entry_pos == 2) entry_left = 16'(b);
          else if (entry_pos == 3) entry_left |= 16'(b) << 8;
          ext_left--;
          entry_pos++;
          if (err == 0 && entry_pos == 4) begin
            if (32'(entry_left) > ext_left) err = lrsd_pkg::ST_EXTENSION;
            else if (entry_type == key_type) begin
              if (have_key || entry_left == 0 || entry_left > key_lim)
                err = lrsd_pkg::ST_EXTENSION;
              have_key = 1;
            end else if (entry_type == meta_type) begin
              if (have_meta || entry_left != 16) err = lrsd_pkg::ST_EXTENSION;
              have_meta = 1;
              meta_crc = '1;
            end
            if (err == 0) begin
              if (entry_left == 0) entry_done();
              else ph = lrsd_pkg::PH_TLV_BODY;
            end
          end
        end
        lrsd_pkg::PH_TLV_BODY: begin
          ext_left--;
          if (entry_type == key_type) emit = lrsd_pkg::KIND_KEY;
          else if (entry_type == meta_type) begin
            mp = (16 - entry_left) & 15;
            meta_buf[mp] = b;
            if (mp < 12) meta_crc = crc_step(meta_crc, b);
          end
          entry_left--;
          if (entry_left == 0) begin
            if (entry_type != key_type && entry_type == meta_type) begin
              v = meta_word(0, 4);
              if ((meta_crc ^ 32'hFFFF_FFFF) != meta_word(12, 4)) err = lrsd_pkg::ST_META_CRC;
              else if (v != legacy_ver && v != current_ver) err = lrsd_pkg::ST_VERSION;
            end
            entry_done();
          end
        end
        default: begin
          pay_crc = crc_step(pay_crc, b);
          pay_count++;
          emit = lrsd_pkg::KIND_PAYLOAD;
        end
      endcase
    end
    if (emit >= 0 && err == 0) begin
      it = '{kind: 2'(emit), out_byte: b, default: '0};
      owed.push_back(it);
    end
    if (last) begin
      if (count < 28 || count != decl_len) st = lrsd_pkg::ST_HEADER;
      else if (err != 0) st = err;
      else if (ph != lrsd_pkg::PH_PAYLOAD) st = lrsd_pkg::ST_HEADER;
      else if (pay_count == 0) st = lrsd_pkg::ST_EMPTY;
      else if ((pay_crc ^ 32'hFFFF_FFFF) != decl_crc) st = lrsd_pkg::ST_PAYLOAD_CRC;
      else st = lrsd_pkg::ST_OK;
      it = '{kind: lrsd_pkg::KIND_SUMMARY, status: st, eor: 1'b1, default: '0};
      if (st == lrsd_pkg::ST_OK) begin
        it.rec_id = id_word;
        it.flags = flag_word;
        it.ver = have_meta ? meta_word(0, 4) : legacy_ver;
        it.enq_time = have_meta ? meta_word(4, 8) : 64'd0;
        it.pay_len = pay_count;
      end
      owed.push_back(it);
      clear();
    end
  endfunction

  function void field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endfunction

  // Compares one accepted result with the oldest owed item.
  function void check_result(logic [239:0] d, logic [1:0] user, logic tl);
    item_t e;
    if (owed.size() == 0) begin
      $error("unexpected result transfer: kind %0d data %0h", user, d);
      fails++;
      return;
    end
    e = owed.pop_front();
    field("item_kind", e.kind, user);
    field("out_byte", e.out_byte, d[7:0]);
    field("status", e.status, d[10:8]);
    field("record_id", e.rec_id, d[74:11]);
    field("record_flags", e.flags, d[106:75]);
    field("version", e.ver, d[138:107]);
    field("enqueue_time", e.enq_time, d[202:139]);
    field("payload_length", e.pay_len, d[234:203]);
    field("end_of_record", e.eor, tl);
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lrsd_pkg::*;

  typedef enum int {
    F_NONE, F_MAGIC, F_EXT_BIG, F_DECL_SHORT, F_RUN_SHORT, F_RUN_LONG, F_ENTRY_CUT,
    F_ENTRY_LONG, F_KEY_DUP, F_KEY_EMPTY, F_KEY_BIG, F_META_DUP, F_META_LEN,
    F_META_CRC, F_VERSION, F_EMPTY, F_PAY_CRC, F_NOISE
  } fault_t;

  localparam int CycleLimit = 600000;

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [7:0]   s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [239:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid, cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  record_scoreboard sb;
  logic [7:0] run_bytes[$];
  int  cycles = 0;
  bit  tx_idle, rx_idle, rx_hold_req;
  int  rx_gap;
  int  rx_hold;

  log_record_stream_decoder_core i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: check each transfer at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Result side: ready with random gaps and an occasional long hold-off.
  initial begin
    rx_gap = 0;
    rx_hold = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && rx_hold == 0) begin
        rx_hold = 300;
        rx_hold_req = 0;
      end
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idle && $urandom_range(0, 5) == 0)
          rx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int n;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(b, last);
  endtask

  task automatic send_run();
    foreach (run_bytes[i]) send_byte(run_bytes[i], i == run_bytes.size() - 1);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits until every owed result has left and the block has settled.
  task automatic wait_drained();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void push_entry(ref logic [7:0] q[$], input logic [7:0] t,
                                     input logic [7:0] body[$]);
    q.push_back(t);
    q.push_back(8'($urandom));
    q.push_back(8'(body.size()));
    q.push_back(8'(body.size() >> 8));
    foreach (body[i]) q.push_back(body[i]);
  endfunction

  // Builds one record into run_bytes, damaged in the way the fault asks.
  task automatic build_record(input fault_t f);
    logic [7:0] ext[$], pay[$], body[$], hdr[$];
    logic [31:0] ext_field, total, pcrc, ver, mcrc, magic;
    logic [63:0] id, et;
    logic [7:0] ut;
    int klen, plen, kmax;
    ext = {};
    pay = {};
    run_bytes = {};
    if (f == F_NOISE) begin
      repeat ($urandom_range(1, 40)) run_bytes.push_back(8'($urandom));
      return;
    end
    // Unknown entry, skipped by the block.
    if ($urandom_range(0, 3) == 0) begin
      do ut = 8'($urandom); while (ut == sb.key_type || ut == sb.meta_type);
      body = {};
      repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
      push_entry(ext, ut, body);
    end
    // Hash key.
    kmax = (sb.key_lim < 5) ? sb.key_lim : 5;
    if (f == F_KEY_EMPTY) klen = 0;
    else if (f == F_KEY_BIG && sb.key_lim < 20) klen = sb.key_lim + 1;
    else klen = $urandom_range(1, kmax);
    if (f inside {F_KEY_EMPTY, F_KEY_BIG, F_KEY_DUP} || $urandom_range(0, 2) != 0) begin
      body = {};
      repeat (klen) body.push_back(8'($urandom));
      push_entry(ext, sb.key_type, body);
      if (f == F_KEY_DUP) push_entry(ext, sb.key_type, body);
    end
    // Metadata.
    if (f inside {F_META_DUP, F_META_LEN, F_META_CRC, F_VERSION} || $urandom_range(0, 1)) begin
      ver = $urandom_range(0, 1) ? sb.legacy_ver : sb.current_ver;
      if (f == F_VERSION)
        do ver = $urandom; while (ver == sb.legacy_ver || ver == sb.current_ver);
      et = {32'($urandom), 32'($urandom)};
      body = {};
      for (int i = 0; i < 4; i++) body.push_back(ver[8*i +: 8]);
      for (int i = 0; i < 8; i++) body.push_back(et[8*i +: 8]);
      mcrc = '1;
      foreach (body[i]) mcrc = sb.crc_step(mcrc, body[i]);
      mcrc = mcrc ^ 32'hFFFF_FFFF;
      if (f == F_META_CRC) mcrc[$urandom_range(0, 31)] ^= 1'b1;
      for (int i = 0; i < 4; i++) body.push_back(mcrc[8*i +: 8]);
      if (f == F_META_LEN) void'(body.pop_back());
      push_entry(ext, sb.meta_type, body);
      if (f == F_META_DUP) push_entry(ext, sb.meta_type, body);
    end
    if (f == F_ENTRY_CUT) begin
      ext.push_back(8'($urandom));
      ext.push_back(8'($urandom));
    end
    if (f == F_ENTRY_LONG) begin
      ext.push_back(sb.key_type);
      ext.push_back(8'h00);
      ext.push_back(8'hC8);
      ext.push_back(8'h00);
    end
    // Payload.
    plen = (f == F_EMPTY) ? 0 : (($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8));
    repeat (plen) pay.push_back(8'($urandom));
    pcrc = '1;
    foreach (pay[i]) pcrc = sb.crc_step(pcrc, pay[i]);
    pcrc = pcrc ^ 32'hFFFF_FFFF;
    if (f == F_PAY_CRC) pcrc[$urandom_range(0, 31)] ^= 1'b1;
    ext_field = ext.size();
    if (f == F_EXT_BIG) ext_field = 32'(sb.ext_lim) + $urandom_range(1, 3);
    total = 28 + ext.size() + pay.size();
    if (f == F_DECL_SHORT) total = 28 + ext.size() - 1;
    magic = sb.magic;
    if (f == F_MAGIC) magic[$urandom_range(0, 31)] ^= 1'b1;
    id = {32'($urandom), 32'($urandom)};
    hdr = {};
    for (int i = 0; i < 4; i++) hdr.push_back(magic[8*i +: 8]);
    for (int i = 0; i < 4; i++) hdr.push_back(total[8*i +: 8]);
    for (int i = 0; i < 8; i++) hdr.push_back(id[8*i +: 8]);
    for (int i = 0; i < 4; i++) hdr.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) hdr.push_back(pcrc[8*i +: 8]);
    for (int i = 0; i < 4; i++) hdr.push_back(ext_field[8*i +: 8]);
    run_bytes = {hdr, ext, pay};
    if (f == F_RUN_SHORT) run_bytes = run_bytes[0 : $urandom_range(0, run_bytes.size() - 2)];
    if (f == F_RUN_LONG) run_bytes.push_back(8'($urandom));
  endtask

  // Register settings per phase, extremes among them.
  task automatic configure(input int p);
    case (p)
      0: begin
        write_reg(REG_MAGIC, 32'h0); write_reg(REG_KEY_TYPE, 32'd1);
        write_reg(REG_META_TYPE, 32'd2); write_reg(REG_LEGACY, 32'd1);
        write_reg(REG_CURRENT, 32'd2); write_reg(REG_EXT_LIM, 32'd1024);
        write_reg(REG_KEY_LIM, 32'd256);
      end
      1: begin
        write_reg(REG_MAGIC, 32'hFFFF_FFFF); write_reg(REG_KEY_TYPE, 32'd0);
        write_reg(REG_META_TYPE, 32'd255); write_reg(REG_LEGACY, 32'h0);
        write_reg(REG_CURRENT, 32'hFFFF_FFFF); write_reg(REG_EXT_LIM, 32'd65535);
        write_reg(REG_KEY_LIM, 32'd65535);
      end
      2: begin
        write_reg(REG_MAGIC, $urandom); write_reg(REG_KEY_TYPE, 32'd255);
        write_reg(REG_META_TYPE, 32'd0); write_reg(REG_LEGACY, $urandom);
        write_reg(REG_CURRENT, $urandom); write_reg(REG_EXT_LIM, 32'd40);
        write_reg(REG_KEY_LIM, 32'd1);
      end
      default: begin
        write_reg(REG_MAGIC, $urandom); write_reg(REG_KEY_TYPE, $urandom_range(0, 255));
        write_reg(REG_META_TYPE, $urandom_range(0, 255)); write_reg(REG_LEGACY, $urandom);
        write_reg(REG_CURRENT, $urandom); write_reg(REG_EXT_LIM, $urandom_range(0, 60));
        write_reg(REG_KEY_LIM, $urandom_range(1, 8));
      end
    endcase
  endtask

  initial begin
    int sent;
    fault_t f;
    sb = new();
    tx_idle = 1; rx_idle = 1; rx_hold_req = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = 8'h00; s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_MAGIC; cfg_data = 32'h0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      configure(p);
      tx_idle = (p != 2);
      rx_idle = (p != 2);
      sent = 0;
      if (p == 1) rx_hold_req = 1;
      // Directed records: every fault kind once, over the first two phases.
      for (int k = F_NONE; k <= F_NOISE; k++) begin
        if (k % 2 == p) begin
          build_record(fault_t'(k));
          sent += run_bytes.size();
          send_run();
        end
      end
      // In the first phase the sender pauses until every result is out.
      if (p == 0) wait_drained();
      while (sent < 30) begin
        if ($urandom_range(0, 9) < 6) f = F_NONE;
        else f = fault_t'($urandom_range(F_MAGIC, F_NOISE));
        build_record(f);
        sent += run_bytes.size();
        send_run();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
